// File: rtl/apq_pkg.sv
// shared types and constants for the aging priority queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ENQ  = 2'd1,
    ACT_DEQ  = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_NO_HIGH = 2'd3
  } status_t;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_AGING    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd2;

  localparam logic [4:0]  CAPACITY_RST = 5'd10;
  localparam logic [15:0] AGING_RST    = 16'd2000;
  localparam logic [15:0] TIMEOUT_RST  = 16'd4000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_INC,
    S_TO_RD,
    S_TO_EV,
    S_DEC_RD,
    S_DEC_EV,
    S_ENQ_CHK,
    S_ENQ_FIND,
    S_DQ_RD,
    S_DQ_EV,
    S_DQ_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    latch_in;
    logic    tick_inc;
    logic    idx_inc;
    logic    didx_clr;
    logic    didx_inc;
    logic    rd_dec;
    logic    to_eval;
    logic    dec_eval;
    logic    enq_write;
    logic    dq_eval;
    logic    dq_take;
    logic    set_st;
    status_t st;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic to_hit;
    logic idx_last;
    logic didx_last;
    logic full;
    logic slot_free;
    logic dq_none;
    logic dq_refuse;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/apq_ctrl.sv
// sequencer for tick, enqueue and dequeue scans over the slot memory
// depends on apq_pkg
`timescale 1ns / 1ps
`default_nettype none

module apq_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  input  wire [1:0]        action,
  input  wire              out_free,
  input  apq_pkg::stat_t   stat,
  output logic             busy,
  output apq_pkg::cmd_t    cmd
);

  apq_pkg::state_t state, state_next;
  logic ret_tick, ret_tick_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= apq_pkg::S_IDLE;
      ret_tick <= 1'b0;
    end else begin
      state    <= state_next;
      ret_tick <= ret_tick_next;
    end
  end

  always_comb begin
    state_next    = state;
    ret_tick_next = ret_tick;
    unique case (state)
      apq_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (apq_pkg::action_t'(action))
            apq_pkg::ACT_TICK: state_next = apq_pkg::S_TICK_INC;
            apq_pkg::ACT_ENQ:  state_next = apq_pkg::S_ENQ_CHK;
            apq_pkg::ACT_DEQ:  state_next = apq_pkg::S_DQ_RD;
            apq_pkg::ACT_NOP:  state_next = apq_pkg::S_DONE;
            default:           state_next = apq_pkg::S_DONE;
          endcase
        end
      end
      apq_pkg::S_TICK_INC: state_next = apq_pkg::S_TO_RD;
      apq_pkg::S_TO_RD:    state_next = apq_pkg::S_TO_EV;
      apq_pkg::S_TO_EV: begin
        if (stat.to_hit) begin
          state_next    = apq_pkg::S_DEC_RD;
          ret_tick_next = 1'b1;
        end else if (stat.idx_last) begin
          state_next = apq_pkg::S_DONE;
        end else begin
          state_next = apq_pkg::S_TO_RD;
        end
      end
      apq_pkg::S_DEC_RD: state_next = apq_pkg::S_DEC_EV;
      apq_pkg::S_DEC_EV: begin
        if (!stat.didx_last) begin
          state_next = apq_pkg::S_DEC_RD;
        end else if (ret_tick && !stat.idx_last) begin
          state_next = apq_pkg::S_TO_RD;
        end else begin
          state_next = apq_pkg::S_DONE;
        end
      end
      apq_pkg::S_ENQ_CHK: begin
        state_next = stat.full ? apq_pkg::S_DONE : apq_pkg::S_ENQ_FIND;
      end
      apq_pkg::S_ENQ_FIND: begin
        if (stat.slot_free) state_next = apq_pkg::S_DONE;
      end
      apq_pkg::S_DQ_RD: state_next = apq_pkg::S_DQ_EV;
      apq_pkg::S_DQ_EV: begin
        state_next = stat.idx_last ? apq_pkg::S_DQ_END : apq_pkg::S_DQ_RD;
      end
      apq_pkg::S_DQ_END: begin
        if (stat.dq_none || stat.dq_refuse) begin
          state_next = apq_pkg::S_DONE;
        end else begin
          state_next    = apq_pkg::S_DEC_RD;
          ret_tick_next = 1'b0;
        end
      end
      apq_pkg::S_DONE: begin
        if (out_free) state_next = apq_pkg::S_IDLE;
      end
      default: state_next = apq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != apq_pkg::S_IDLE);
    unique case (state)
      apq_pkg::S_IDLE:     cmd.latch_in = in_valid;
      apq_pkg::S_TICK_INC: cmd.tick_inc = 1'b1;
      apq_pkg::S_TO_RD:    ;
      apq_pkg::S_TO_EV: begin
        cmd.to_eval = 1'b1;
        if (stat.to_hit) begin
          cmd.didx_clr = 1'b1;
        end else if (!stat.idx_last) begin
          cmd.idx_inc = 1'b1;
        end
      end
      apq_pkg::S_DEC_RD: cmd.rd_dec = 1'b1;
      apq_pkg::S_DEC_EV: begin
        cmd.rd_dec   = 1'b1;
        cmd.dec_eval = 1'b1;
        if (!stat.didx_last) begin
          cmd.didx_inc = 1'b1;
        end else if (ret_tick && !stat.idx_last) begin
          cmd.idx_inc = 1'b1;
        end
      end
      apq_pkg::S_ENQ_CHK: begin
        if (stat.full) begin
          cmd.set_st = 1'b1;
          cmd.st     = apq_pkg::ST_FULL;
        end
      end
      apq_pkg::S_ENQ_FIND: begin
        if (stat.slot_free) cmd.enq_write = 1'b1;
        else cmd.idx_inc = 1'b1;
      end
      apq_pkg::S_DQ_RD: ;
      apq_pkg::S_DQ_EV: begin
        cmd.dq_eval = 1'b1;
        if (!stat.idx_last) cmd.idx_inc = 1'b1;
      end
      apq_pkg::S_DQ_END: begin
        if (stat.dq_none) begin
          cmd.set_st = 1'b1;
          cmd.st     = apq_pkg::ST_EMPTY;
        end else if (stat.dq_refuse) begin
          cmd.set_st = 1'b1;
          cmd.st     = apq_pkg::ST_NO_HIGH;
        end else begin
          cmd.dq_take  = 1'b1;
          cmd.didx_clr = 1'b1;
        end
      end
      apq_pkg::S_DONE: cmd.res_load = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/apq_dp.sv
// slot memory, valid bits, tick counter, config registers and scan datapath
// depends on apq_pkg
`timescale 1ns / 1ps
`default_nettype none

module apq_dp #(
  parameter int SLOTS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data,
  input  wire  [15:0]         item_id,
  input  wire                 base_priority,
  input  wire                 high_only,
  input  apq_pkg::cmd_t       cmd,
  output apq_pkg::stat_t      stat,
  output logic [1:0]          res_status,
  output logic [15:0]         res_id,
  output logic                res_high,
  output logic [15:0]         res_wait,
  output logic [4:0]          res_cancelled,
  output logic [4:0]          res_occupancy
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = (CW > 5) ? CW : 5;

  typedef struct packed {
    logic [15:0]   id;
    logic          base;
    logic          eff;
    logic [31:0]   arrival;
    logic [IW-1:0] rank;
  } entry_t;

  entry_t mem [SLOTS];
  entry_t rdata;
  entry_t wr_data;
  logic   wr_en;
  logic [IW-1:0] wr_addr;

  logic [SLOTS-1:0] valid;
  logic [CW-1:0]    count;
  logic [31:0]      now_ticks;
  logic [4:0]       capacity;
  logic [15:0]      aging_threshold;
  logic [15:0]      timeout_limit;

  logic [IW-1:0] idx;
  logic [IW-1:0] didx;
  logic [IW-1:0] raddr;
  logic [IW-1:0] rem_rank;

  logic [15:0]   id_q;
  logic          base_q;
  logic          ho_q;
  apq_pkg::status_t st_q;
  logic [CW-1:0] cancelled;

  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [15:0]   best_id;
  logic          best_eff;
  logic [31:0]   best_arr;
  logic [IW-1:0] best_rank;

  logic [31:0] wait_cur;
  logic [31:0] wait_best;
  logic        better;

  assign raddr     = cmd.rd_dec ? didx : idx;
  assign wait_cur  = now_ticks - rdata.arrival;
  assign wait_best = now_ticks - best_arr;
  assign better    = !best_found || (rdata.eff && !best_eff) ||
                     ((rdata.eff == best_eff) && (rdata.rank < best_rank));

  assign stat.to_hit    = valid[idx] && (wait_cur > {16'd0, timeout_limit});
  assign stat.idx_last  = (idx == IW'(SLOTS - 1));
  assign stat.didx_last = (didx == IW'(SLOTS - 1));
  assign stat.full      = (KW'(count) >= KW'(capacity)) || (KW'(count) >= KW'(SLOTS));
  assign stat.slot_free = !valid[idx];
  assign stat.dq_none   = !best_found;
  assign stat.dq_refuse = ho_q && !best_eff;

  // memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = rdata;
    priority if (cmd.enq_write) begin
      wr_en           = 1'b1;
      wr_data.id      = id_q;
      wr_data.base    = base_q;
      wr_data.eff     = base_q;
      wr_data.arrival = now_ticks;
      wr_data.rank    = IW'(count);
    end else if (cmd.to_eval) begin
      wr_en       = valid[idx] && !stat.to_hit && !rdata.base && !rdata.eff &&
                    (wait_cur >= {16'd0, aging_threshold});
      wr_data.eff = 1'b1;
    end else if (cmd.dec_eval) begin
      wr_en        = valid[didx] && (rdata.rank > rem_rank);
      wr_addr      = didx;
      wr_data.rank = rdata.rank - IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= apq_pkg::CAPACITY_RST;
      aging_threshold <= apq_pkg::AGING_RST;
      timeout_limit   <= apq_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apq_pkg::CFG_CAPACITY: capacity        <= cfg_data[4:0];
        apq_pkg::CFG_AGING:    aging_threshold <= cfg_data;
        apq_pkg::CFG_TIMEOUT:  timeout_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      count      <= '0;
      now_ticks  <= '0;
      idx        <= '0;
      didx       <= '0;
      best_found <= 1'b0;
      st_q       <= apq_pkg::ST_OK;
      cancelled  <= '0;
    end else begin
      if (cmd.latch_in) begin
        idx        <= '0;
        didx       <= '0;
        best_found <= 1'b0;
        st_q       <= apq_pkg::ST_OK;
        cancelled  <= '0;
      end
      if (cmd.tick_inc) now_ticks <= now_ticks + 32'd1;
      if (cmd.idx_inc)  idx <= idx + IW'(1);
      if (cmd.didx_clr) didx <= '0;
      if (cmd.didx_inc) didx <= didx + IW'(1);
      if (cmd.set_st)   st_q <= cmd.st;
      if (cmd.to_eval && stat.to_hit) begin
        valid[idx] <= 1'b0;
        count      <= count - CW'(1);
        cancelled  <= cancelled + CW'(1);
      end
      if (cmd.enq_write) begin
        valid[idx] <= 1'b1;
        count      <= count + CW'(1);
      end
      if (cmd.dq_eval && valid[idx] && better) begin
        best_found <= 1'b1;
      end
      if (cmd.dq_take) begin
        valid[best_idx] <= 1'b0;
        count           <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      id_q     <= item_id;
      base_q   <= base_priority;
      ho_q     <= high_only;
      res_id   <= '0;
      res_high <= 1'b0;
      res_wait <= '0;
    end
    if (cmd.to_eval && stat.to_hit) rem_rank <= rdata.rank;
    if (cmd.dq_eval && valid[idx] && better) begin
      best_idx  <= idx;
      best_id   <= rdata.id;
      best_eff  <= rdata.eff;
      best_arr  <= rdata.arrival;
      best_rank <= rdata.rank;
    end
    if (cmd.dq_take) begin
      rem_rank <= best_rank;
      res_id   <= best_id;
      res_high <= best_eff;
      res_wait <= (wait_best > 32'h0000_FFFF) ? 16'hFFFF : wait_best[15:0];
    end
  end

  assign res_status    = st_q;
  assign res_cancelled = 5'(cancelled);
  assign res_occupancy = 5'(count);

endmodule

`default_nettype wire

// File: rtl/aging_priority_queue_timeout.sv
// two-level priority queue with aging and timeout, top level with result register
// depends on apq_pkg, apq_ctrl, apq_dp
// enqueue searches the slots for a free one; tick and dequeue scan every slot, and every
// timed-out or dequeued entry adds a rank update pass over all slots
// one request at a time: in_stall is high until the controller is back in idle
// synchronous reset empties the queue, clears the tick count and loads config defaults
`timescale 1ns / 1ps
`default_nettype none

module aging_priority_queue_timeout #(
  parameter int SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  action,
  input  wire  [15:0] item_id,
  input  wire         base_priority,
  input  wire         high_only,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  status,
  output logic [15:0] out_id,
  output logic        out_high,
  output logic [15:0] out_wait,
  output logic [4:0]  cancelled_now,
  output logic [4:0]  occupancy
);

  apq_pkg::cmd_t  cmd;
  apq_pkg::stat_t stat;
  logic           busy;
  logic           out_free;
  logic [1:0]     res_status;
  logic [15:0]    res_id;
  logic           res_high;
  logic [15:0]    res_wait;
  logic [4:0]     res_cancelled;
  logic [4:0]     res_occupancy;

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  apq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .out_free (out_free),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  apq_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_id       (item_id),
    .base_priority (base_priority),
    .high_only     (high_only),
    .cmd           (cmd),
    .stat          (stat),
    .res_status    (res_status),
    .res_id        (res_id),
    .res_high      (res_high),
    .res_wait      (res_wait),
    .res_cancelled (res_cancelled),
    .res_occupancy (res_occupancy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status        <= res_status;
      out_id        <= res_id;
      out_high      <= res_high;
      out_wait      <= res_wait;
      cancelled_now <= res_cancelled;
      occupancy     <= res_occupancy;
    end
  end

endmodule

`default_nettype wire
